FILE: sv/ffba_pkg.sv
package ffba_pkg;

    localparam int unsigned ARENA_BYTES = 1048576;
    localparam int unsigned SLOT_COUNT  = ARENA_BYTES / 16;
    localparam int unsigned SLOT_W      = $clog2(SLOT_COUNT);
    localparam int unsigned LINK_W      = SLOT_W + 1;
    localparam int unsigned SIZE_W      = SLOT_W + 1;
    localparam int unsigned ADDR_W      = 20;
    localparam int unsigned USE_W       = 21;
    localparam int unsigned AL_W        = 29;
    localparam int unsigned HDR_W       = SIZE_W + 2 * LINK_W + 1;

    localparam logic [1:0] OP_RESET  = 2'd0;
    localparam logic [1:0] OP_ALLOC  = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;
    localparam logic [1:0] OP_RESIZE = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FAILED    = 2'd1;
    localparam logic [1:0] ST_UNMATCHED = 2'd2;
    localparam logic [1:0] ST_NULL      = 2'd3;

    typedef struct packed {
        logic [1:0]        operation;
        logic [31:0]       request_size;
        logic [ADDR_W-1:0] block_address;
        logic              address_is_null;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [1:0]        status;
        logic [USE_W-1:0]  bytes_in_use;
        logic [USE_W-1:0]  peak_in_use;
        logic [31:0]       allocation_count;
        logic [31:0]       largest_request;
        logic [31:0]       failed_request;
        logic [31:0]       free_count;
        logic [31:0]       free_matched;
        logic [31:0]       free_unmatched;
    } out_item_t;

    // block header, size in 16-byte units, links are slot+1 with 0 for none
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
        logic              free;
    } hdr_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RESET_ARENA,
        CMD_NULL_FREE,
        CMD_A_INIT,
        CMD_A_WALK,
        CMD_A_SPLIT,
        CMD_RD_LINK,
        CMD_WR_LINK,
        CMD_RD_CUR,
        CMD_A_COMMIT,
        CMD_RD_B,
        CMD_F_START,
        CMD_F_CHK,
        CMD_F_NEXT,
        CMD_F_MERGE_N,
        CMD_F_PREV,
        CMD_F_MERGE_P,
        CMD_F_DONE,
        CMD_R_KEEP,
        CMD_OUT_LOAD
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       is_null;
        logic       req_zero;
        logic       too_big;
        logic       fit;
        logic       walk_stop;
        logic       split;
        logic       rd_free;
        logic       rd_next_zero;
        logic       rd_prev_zero;
        logic       hc_next_zero;
        logic       hb_next_zero;
        logic       addr_ok;
        logic       old_ge;
        logic       out_free;
    } dp_status_t;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [LINK_W-1:0] link);
        slot_of = SLOT_W'(link - LINK_W'(1));
    endfunction

endpackage

FILE: sv/ffba_ram.sv
module ffba_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/ffba_dpath.sv
module ffba_dpath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ffba_pkg::in_item_t    s_data,
    input  ffba_pkg::cmd_t        cmd,
    input  logic                  m_ready,
    output logic                  m_valid,
    output ffba_pkg::out_item_t   m_data,
    output ffba_pkg::dp_status_t  status
);
    import ffba_pkg::*;

    in_item_t          in_reg;
    logic [SLOT_W-1:0] b_reg, cur_reg, steps_reg, link_reg;
    logic [LINK_W-1:0] val_reg;
    logic [AL_W-1:0]   al_reg;
    hdr_t              hc_reg, hb_reg;
    logic [ADDR_W-1:0] res_reg;
    logic [1:0]        st_reg;
    logic [USE_W-1:0]  used_reg, peak_reg;
    logic [31:0]       alloc_cnt_reg, largest_reg, failed_reg;
    logic [31:0]       free_cnt_reg, matched_reg, unmatched_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic              ram_we, ram_re;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    hdr_t              ram_wdata, rd;
    logic [HDR_W-1:0]  ram_rdata;

    logic [31:0]       size32;
    logic              fit, walk_stop, split, addr_ok;
    logic [SLOT_W-1:0] ns, p_slot;
    logic [LINK_W-1:0] cur_link;
    logic [SIZE_W-1:0] commit_size;
    logic [USE_W-1:0]  used_add;

    ffba_ram #(.WIDTH(HDR_W), .DEPTH(SLOT_COUNT)) u_hdr_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd        = hdr_t'(ram_rdata);
    assign size32    = (in_reg.request_size == 32'd0) ? 32'd1 : in_reg.request_size;
    assign fit       = rd.free && ({(AL_W - SIZE_W)'(0), rd.size} >= al_reg);
    assign walk_stop = (rd.next == '0) || (steps_reg == SLOT_W'(SLOT_COUNT - 1));
    assign split     = ({1'b0, (AL_W - SIZE_W)'(0), hc_reg.size}
                        >= ({1'b0, al_reg} + (AL_W + 1)'(2)));
    assign cur_link  = {1'b0, cur_reg} + LINK_W'(1);
    assign ns        = SLOT_W'(cur_link + LINK_W'(al_reg[SLOT_W-1:0]));
    assign p_slot    = slot_of(hb_reg.prev);
    assign addr_ok   = (in_reg.block_address[3:0] == 4'd0)
                    && (in_reg.block_address[ADDR_W-1:4] != '0);
    assign commit_size = split ? al_reg[SIZE_W-1:0] : rd.size;
    assign used_add  = used_reg + USE_W'({commit_size, 4'd0});

    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = '0;
        ram_raddr = '0;
        ram_wdata = rd;
        case (cmd)
            CMD_RESET_ARENA: begin
                ram_we    = 1'b1;
                ram_wdata = '{size: SIZE_W'(SLOT_COUNT - 1), next: '0, prev: '0, free: 1'b1};
            end
            CMD_A_INIT: ram_re = 1'b1;
            CMD_A_WALK: begin
                ram_re    = 1'b1;
                ram_raddr = slot_of(rd.next);
            end
            CMD_A_SPLIT: begin
                ram_we    = 1'b1;
                ram_waddr = ns;
                ram_wdata = '{size: SIZE_W'(hc_reg.size - al_reg[SIZE_W-1:0] - SIZE_W'(1)),
                              next: hc_reg.next, prev: cur_link, free: 1'b1};
            end
            CMD_RD_LINK: begin
                ram_re    = 1'b1;
                ram_raddr = link_reg;
            end
            CMD_WR_LINK: begin
                ram_we         = 1'b1;
                ram_waddr      = link_reg;
                ram_wdata.prev = val_reg;
            end
            CMD_RD_CUR: begin
                ram_re    = 1'b1;
                ram_raddr = cur_reg;
            end
            CMD_A_COMMIT: begin
                ram_we         = 1'b1;
                ram_waddr      = cur_reg;
                ram_wdata.free = 1'b0;
                ram_wdata.size = commit_size;
                if (split) begin
                    ram_wdata.next = {1'b0, ns} + LINK_W'(1);
                end
            end
            CMD_RD_B, CMD_F_START: begin
                ram_re    = 1'b1;
                ram_raddr = b_reg;
            end
            CMD_F_CHK: begin
                ram_we         = !rd.free;
                ram_waddr      = b_reg;
                ram_wdata.free = 1'b1;
            end
            CMD_F_NEXT: begin
                ram_re    = 1'b1;
                ram_raddr = slot_of(rd.next);
            end
            CMD_F_MERGE_N: begin
                ram_we    = 1'b1;
                ram_waddr = b_reg;
                ram_wdata = '{size: SIZE_W'(hb_reg.size + SIZE_W'(1) + rd.size),
                              next: rd.next, prev: hb_reg.prev, free: hb_reg.free};
            end
            CMD_F_PREV: begin
                ram_re    = 1'b1;
                ram_raddr = slot_of(rd.prev);
            end
            CMD_F_MERGE_P: begin
                ram_we         = 1'b1;
                ram_waddr      = p_slot;
                ram_wdata.size = SIZE_W'(rd.size + SIZE_W'(1) + hb_reg.size);
                ram_wdata.next = hb_reg.next;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            peak_reg      <= '0;
            alloc_cnt_reg <= '0;
            largest_reg   <= '0;
            failed_reg    <= '0;
            free_cnt_reg  <= '0;
            matched_reg   <= '0;
            unmatched_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd == CMD_OUT_LOAD) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd)
                CMD_LOAD: begin
                    in_reg  <= s_data;
                    res_reg <= '0;
                    st_reg  <= ST_DONE;
                    b_reg   <= SLOT_W'(s_data.block_address >> 4) - SLOT_W'(1);
                end
                CMD_RESET_ARENA: begin
                    used_reg      <= '0;
                    peak_reg      <= '0;
                    alloc_cnt_reg <= '0;
                    largest_reg   <= '0;
                    failed_reg    <= '0;
                    free_cnt_reg  <= '0;
                    matched_reg   <= '0;
                    unmatched_reg <= '0;
                end
                CMD_NULL_FREE: st_reg <= ST_NULL;
                CMD_A_INIT: begin
                    if (status.too_big) begin
                        st_reg <= ST_FAILED;
                    end
                    al_reg    <= AL_W'(({1'b0, size32} + 33'd15) >> 4);
                    cur_reg   <= '0;
                    steps_reg <= '0;
                end
                CMD_A_WALK: begin
                    if (fit) begin
                        hc_reg <= rd;
                    end else if (walk_stop) begin
                        failed_reg <= size32;
                        st_reg     <= ST_FAILED;
                    end else begin
                        cur_reg   <= slot_of(rd.next);
                        steps_reg <= steps_reg + SLOT_W'(1);
                    end
                end
                CMD_A_SPLIT: begin
                    link_reg <= slot_of(hc_reg.next);
                    val_reg  <= {1'b0, ns} + LINK_W'(1);
                end
                CMD_A_COMMIT: begin
                    used_reg      <= used_add;
                    if (used_add > peak_reg) begin
                        peak_reg <= used_add;
                    end
                    if (size32 > largest_reg) begin
                        largest_reg <= size32;
                    end
                    alloc_cnt_reg <= alloc_cnt_reg + 32'd1;
                    res_reg       <= {cur_link[SLOT_W-1:0], 4'd0};
                    st_reg        <= ST_DONE;
                end
                CMD_F_START: begin
                    free_cnt_reg <= free_cnt_reg + 32'd1;
                    if (!addr_ok) begin
                        unmatched_reg <= unmatched_reg + 32'd1;
                        st_reg        <= ST_UNMATCHED;
                    end
                end
                CMD_F_CHK: begin
                    if (rd.free) begin
                        unmatched_reg <= unmatched_reg + 32'd1;
                        st_reg        <= ST_UNMATCHED;
                    end else begin
                        used_reg <= used_reg - USE_W'({rd.size, 4'd0});
                    end
                end
                CMD_F_NEXT, CMD_F_PREV: hb_reg <= rd;
                CMD_F_MERGE_N: begin
                    link_reg <= slot_of(rd.next);
                    val_reg  <= {1'b0, b_reg} + LINK_W'(1);
                end
                CMD_F_MERGE_P: begin
                    link_reg <= slot_of(hb_reg.next);
                    val_reg  <= hb_reg.prev;
                end
                CMD_F_DONE: begin
                    matched_reg <= matched_reg + 32'd1;
                    st_reg      <= ST_DONE;
                end
                CMD_R_KEEP: begin
                    res_reg <= in_reg.block_address;
                    st_reg  <= ST_DONE;
                end
                CMD_OUT_LOAD: begin
                    m_data_reg  <= '{
                        result_address:   res_reg,
                        status:           st_reg,
                        bytes_in_use:     used_reg,
                        peak_in_use:      peak_reg,
                        allocation_count: alloc_cnt_reg,
                        largest_request:  largest_reg,
                        failed_request:   failed_reg,
                        free_count:       free_cnt_reg,
                        free_matched:     matched_reg,
                        free_unmatched:   unmatched_reg
                    };
                end
                default: ;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        status.op           = in_reg.operation;
        status.is_null      = in_reg.address_is_null;
        status.req_zero     = (in_reg.request_size == 32'd0);
        status.too_big      = (size32 > 32'hFFFF_FFF0);
        status.fit          = fit;
        status.walk_stop    = walk_stop;
        status.split        = split;
        status.rd_free      = rd.free;
        status.rd_next_zero = (rd.next == '0);
        status.rd_prev_zero = (rd.prev == '0);
        status.hc_next_zero = (hc_reg.next == '0);
        status.hb_next_zero = (hb_reg.next == '0);
        status.addr_ok      = addr_ok;
        status.old_ge       = addr_ok
                           && ({(32 - SIZE_W - 4)'(0), rd.size, 4'd0} >= in_reg.request_size);
        status.out_free     = !m_valid_reg || m_ready;
    end

endmodule

FILE: sv/ffba_ctrl.sv
module ffba_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ffba_pkg::dp_status_t  status,
    output ffba_pkg::cmd_t        cmd
);
    import ffba_pkg::*;

    typedef enum logic [20:0] {
        S_IDLE      = 21'd1 << 0,
        S_DISPATCH  = 21'd1 << 1,
        S_A_INIT    = 21'd1 << 2,
        S_A_WALK    = 21'd1 << 3,
        S_A_SPLIT   = 21'd1 << 4,
        S_RD_LINK   = 21'd1 << 5,
        S_WR_LINK   = 21'd1 << 6,
        S_RD_CUR    = 21'd1 << 7,
        S_A_COMMIT  = 21'd1 << 8,
        S_F_START   = 21'd1 << 9,
        S_F_CHK     = 21'd1 << 10,
        S_F_RDB1    = 21'd1 << 11,
        S_F_NEXT    = 21'd1 << 12,
        S_F_MERGE_N = 21'd1 << 13,
        S_F_RDB2    = 21'd1 << 14,
        S_F_PREV    = 21'd1 << 15,
        S_F_MERGE_P = 21'd1 << 16,
        S_F_DONE    = 21'd1 << 17,
        S_R_OLD     = 21'd1 << 18,
        S_R_CHK     = 21'd1 << 19,
        S_FINISH    = 21'd1 << 20
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd        = CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (status.op)
                    OP_RESET: begin
                        cmd        = CMD_RESET_ARENA;
                        state_next = S_FINISH;
                    end
                    OP_ALLOC: state_next = S_A_INIT;
                    OP_FREE: begin
                        if (status.is_null) begin
                            cmd        = CMD_NULL_FREE;
                            state_next = S_FINISH;
                        end else begin
                            state_next = S_F_START;
                        end
                    end
                    default: begin
                        if (status.is_null) begin
                            state_next = S_A_INIT;
                        end else if (status.req_zero) begin
                            state_next = S_F_START;
                        end else begin
                            state_next = S_R_OLD;
                        end
                    end
                endcase
            end
            S_A_INIT: begin
                cmd        = CMD_A_INIT;
                state_next = status.too_big ? S_FINISH : S_A_WALK;
            end
            S_A_WALK: begin
                cmd = CMD_A_WALK;
                if (status.fit) begin
                    state_next = S_A_SPLIT;
                end else if (status.walk_stop) begin
                    state_next = S_FINISH;
                end
            end
            S_A_SPLIT: begin
                state_next = S_RD_CUR;
                if (status.split) begin
                    cmd = CMD_A_SPLIT;
                    if (!status.hc_next_zero) begin
                        ret_next   = S_RD_CUR;
                        state_next = S_RD_LINK;
                    end
                end
            end
            S_RD_LINK: begin
                cmd        = CMD_RD_LINK;
                state_next = S_WR_LINK;
            end
            S_WR_LINK: begin
                cmd        = CMD_WR_LINK;
                state_next = ret_reg;
            end
            S_RD_CUR: begin
                cmd        = CMD_RD_CUR;
                state_next = S_A_COMMIT;
            end
            S_A_COMMIT: begin
                cmd = CMD_A_COMMIT;
                if (status.op == OP_RESIZE && !status.is_null) begin
                    state_next = S_F_START;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_F_START: begin
                cmd        = CMD_F_START;
                state_next = status.addr_ok ? S_F_CHK : S_FINISH;
            end
            S_F_CHK: begin
                cmd        = CMD_F_CHK;
                state_next = status.rd_free ? S_FINISH : S_F_RDB1;
            end
            S_F_RDB1: begin
                cmd        = CMD_RD_B;
                state_next = S_F_NEXT;
            end
            S_F_NEXT: begin
                cmd        = CMD_F_NEXT;
                state_next = status.rd_next_zero ? S_F_RDB2 : S_F_MERGE_N;
            end
            S_F_MERGE_N: begin
                state_next = S_F_RDB2;
                if (status.rd_free) begin
                    cmd = CMD_F_MERGE_N;
                    if (!status.rd_next_zero) begin
                        ret_next   = S_F_RDB2;
                        state_next = S_RD_LINK;
                    end
                end
            end
            S_F_RDB2: begin
                cmd        = CMD_RD_B;
                state_next = S_F_PREV;
            end
            S_F_PREV: begin
                cmd        = CMD_F_PREV;
                state_next = status.rd_prev_zero ? S_F_DONE : S_F_MERGE_P;
            end
            S_F_MERGE_P: begin
                state_next = S_F_DONE;
                if (status.rd_free) begin
                    cmd = CMD_F_MERGE_P;
                    if (!status.hb_next_zero) begin
                        ret_next   = S_F_DONE;
                        state_next = S_RD_LINK;
                    end
                end
            end
            S_F_DONE: begin
                cmd        = CMD_F_DONE;
                state_next = S_FINISH;
            end
            S_R_OLD: begin
                cmd        = CMD_RD_B;
                state_next = S_R_CHK;
            end
            S_R_CHK: begin
                if (status.old_ge) begin
                    cmd        = CMD_R_KEEP;
                    state_next = S_FINISH;
                end else begin
                    state_next = S_A_INIT;
                end
            end
            S_FINISH: begin
                if (status.out_free) begin
                    cmd        = CMD_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

FILE: sv/first_fit_block_allocator_core.sv
// first-fit heap allocator over a 1 MiB arena kept as a doubly linked chain of
// 16-byte headers in a single-port-write, single-port-read header ram (one slot
// per 16-byte line). one transfer in gives exactly one transfer out carrying the
// handed-out address, a status and the usage statistics after the operation.
// items are processed one at a time. an allocate walks the headers from offset 0
// (one header per cycle) and, when the found block is split and has a successor,
// also rewrites that successor's back link. the work of a free depends on which
// neighbors are merged. resize first checks the old block size and then costs an
// allocate plus a free. the output register lets a new transfer in while the
// last result is still waiting. the header ram is not cleared after reset: issue
// a reset-arena operation before anything else
module first_fit_block_allocator_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ffba_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ffba_pkg::out_item_t  m_data
);
    import ffba_pkg::*;

    cmd_t       cmd;
    dp_status_t status;

    // sequencer: walks the chain and orders the header reads and writes
    ffba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // header ram, working registers, statistics and output register
    ffba_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .status  (status)
    );

    // every counted free ends matched or unmatched
    a_free_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_data.free_matched + m_data.free_unmatched) == m_data.free_count))
        else $error("free counters out of balance");

    // a failed allocation hands out no address
    a_fail_null: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_FAILED) |-> (m_data.result_address == '0))
        else $error("failed allocation returned an address");

    // an ignored null free hands out no address
    a_null_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_NULL) |-> (m_data.result_address == '0))
        else $error("null free returned an address");

    // no new transfer in while a result is still being produced
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

endmodule

FILE: sim/tb_first_fit_block_allocator_core.sv
`timescale 1ns / 100ps

module tb_first_fit_block_allocator_core;
    import ffba_pkg::*;

    localparam int unsigned SLOTS     = ARENA_BYTES / 16;
    localparam logic [20:0] SZ_MASK   = 21'h1FFFF0;
    localparam int          STALL_LEN = 300;
    localparam int          IDLE_MAX  = 300000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    first_fit_block_allocator_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // shadow heap: header slots and usage statistics
    bit [20:0]   h_size [SLOTS];
    bit [16:0]   h_next [SLOTS];
    bit [16:0]   h_prev [SLOTS];
    bit          h_free [SLOTS];
    bit          h_written [SLOTS];
    bit [20:0]   used_b, peak_b;
    bit [31:0]   alloc_cnt, largest_sz, fail_sz, free_cnt, match_cnt, unmatch_cnt;

    out_item_t   pending_results[$];
    bit [19:0]   live_addrs[$];
    int          fail_count = 0;
    bit          hold_req = 1'b0;
    int          burst_left = 0;

    function automatic bit [15:0] slot_of_link(bit [16:0] link);
        return 16'(link - 17'd1);
    endfunction

    function automatic bit addr_good(bit [19:0] a);
        return a >= 16 && a[3:0] == 4'd0;
    endfunction

    function automatic void forget_addr(bit [19:0] a);
        foreach (live_addrs[i]) begin
            if (live_addrs[i] == a) begin
                live_addrs.delete(i);
                return;
            end
        end
    endfunction

    function automatic bit [1:0] heap_alloc(bit [31:0] req, output bit [19:0] addr);
        longint unsigned sz, al;
        int unsigned cur, steps, ns;
        bit found;
        addr = '0;
        sz = (req != 0) ? req : 1;
        if (sz > 64'hFFFF_FFFF - 15) return ST_FAILED;
        al = (sz + 15) & ~64'hF;
        cur = 0;
        found = 0;
        for (steps = 0; steps < SLOTS; steps++) begin
            if (h_free[cur] && h_size[cur] >= al) begin
                found = 1;
                break;
            end
            if (h_next[cur] == 0) break;
            cur = slot_of_link(h_next[cur]);
        end
        if (!found) begin
            fail_sz = sz[31:0];
            return ST_FAILED;
        end
        if (h_size[cur] >= al + 32) begin
            ns = (cur + 1 + al / 16) % SLOTS;
            h_size[ns] = 21'(h_size[cur] - al - 16) & SZ_MASK;
            h_next[ns] = h_next[cur];
            h_prev[ns] = 17'(cur + 1);
            h_free[ns] = 1;
            h_written[ns] = 1;
            if (h_next[cur] != 0) h_prev[slot_of_link(h_next[cur])] = 17'(ns + 1);
            h_next[cur] = 17'(ns + 1);
            h_size[cur] = 21'(al) & SZ_MASK;
        end
        h_free[cur] = 0;
        used_b = used_b + h_size[cur];
        if (used_b > peak_b) peak_b = used_b;
        if (sz[31:0] > largest_sz) largest_sz = sz[31:0];
        alloc_cnt++;
        addr = 20'((cur + 1) * 16);
        live_addrs.push_back(addr);
        return ST_DONE;
    endfunction

    function automatic bit [1:0] heap_free(bit [19:0] a);
        int unsigned b, n, p;
        free_cnt++;
        if (!addr_good(a)) begin
            unmatch_cnt++;
            return ST_UNMATCHED;
        end
        b = a / 16 - 1;
        if (h_free[b]) begin
            unmatch_cnt++;
            return ST_UNMATCHED;
        end
        forget_addr(a);
        h_free[b] = 1;
        used_b = used_b - h_size[b];
        if (h_next[b] != 0) begin
            n = slot_of_link(h_next[b]);
            if (h_free[n]) begin
                h_size[b] = (h_size[b] + 21'd16 + h_size[n]) & SZ_MASK;
                h_next[b] = h_next[n];
                if (h_next[n] != 0) h_prev[slot_of_link(h_next[n])] = 17'(b + 1);
            end
        end
        if (h_prev[b] != 0) begin
            p = slot_of_link(h_prev[b]);
            if (h_free[p]) begin
                h_size[p] = (h_size[p] + 21'd16 + h_size[b]) & SZ_MASK;
                h_next[p] = h_next[b];
                if (h_next[b] != 0) h_prev[slot_of_link(h_next[b])] = h_prev[b];
            end
        end
        match_cnt++;
        return ST_DONE;
    endfunction

    // apply one operation to the shadow heap and return the expected result
    function automatic out_item_t heap_apply(in_item_t it);
        out_item_t r;
        bit [19:0] res;
        bit [1:0]  st;
        bit [31:0] old;
        res = '0;
        st = ST_DONE;
        case (it.operation)
            OP_RESET: begin
                used_b = 0; peak_b = 0; alloc_cnt = 0; largest_sz = 0;
                fail_sz = 0; free_cnt = 0; match_cnt = 0; unmatch_cnt = 0;
                h_size[0] = 21'(ARENA_BYTES - 16) & SZ_MASK;
                h_next[0] = 0;
                h_prev[0] = 0;
                h_free[0] = 1;
                h_written[0] = 1;
                live_addrs.delete();
            end
            OP_ALLOC: st = heap_alloc(it.request_size, res);
            OP_FREE: st = it.address_is_null ? ST_NULL : heap_free(it.block_address);
            default: begin
                if (it.address_is_null) begin
                    st = heap_alloc(it.request_size, res);
                end else if (it.request_size == 0) begin
                    st = heap_free(it.block_address);
                end else begin
                    old = addr_good(it.block_address) ?
                          h_size[it.block_address / 16 - 1] : 0;
                    if (old >= it.request_size) begin
                        res = it.block_address;
                    end else begin
                        st = heap_alloc(it.request_size, res);
                        if (st == ST_DONE) st = heap_free(it.block_address);
                    end
                end
            end
        endcase
        r.result_address   = res;
        r.status           = st;
        r.bytes_in_use     = used_b;
        r.peak_in_use      = peak_b;
        r.allocation_count = alloc_cnt;
        r.largest_request  = largest_sz;
        r.failed_request   = fail_sz;
        r.free_count       = free_cnt;
        r.free_matched     = match_cnt;
        r.free_unmatched   = unmatch_cnt;
        return r;
    endfunction

    // one transfer in; assumes the caller sits at a rising edge
    task automatic send_op(logic [1:0] op, logic [31:0] req, logic [19:0] addr,
                           logic is_null);
        in_item_t it;
        it.operation = op;
        it.request_size = req;
        it.block_address = addr;
        it.address_is_null = is_null;
        // never point the block at a header slot it has not written yet
        if ((op == OP_FREE || op == OP_RESIZE) && !is_null && addr_good(addr)
            && !h_written[addr / 16 - 1])
            it.block_address = 20'd16;
        pending_results.push_back(heap_apply(it));
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        // burst / gap pacing
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    function automatic logic [19:0] pick_live();
        if (live_addrs.size() == 0) return 20'd16;
        return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
    endfunction

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 19))
            0:       return $urandom();
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 31);
            2:       return $urandom_range(0, 1);
            3:       return $urandom_range(1000, 60000);
            default: return $urandom_range(1, 600);
        endcase
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (40) @(posedge aclk);
    endtask

    task automatic test_directed();
        logic [19:0] a, b, c;
        send_op(OP_RESET, 0, 0, 0);
        send_op(OP_ALLOC, 0, 0, 0);
        send_op(OP_ALLOC, 1, 0, 0);
        send_op(OP_ALLOC, 16, 0, 0);
        send_op(OP_ALLOC, 17, 0, 0);
        send_op(OP_ALLOC, 32'hFFFF_FFF0, 0, 0);   // largest legal size, no fit
        send_op(OP_ALLOC, 32'hFFFF_FFF1, 0, 0);   // too big, failed size kept
        send_op(OP_ALLOC, 32'hFFFF_FFFF, 0, 0);
        send_op(OP_FREE, 0, 20'hFFFFF, 1);        // null free
        send_op(OP_FREE, 0, 20'd0, 0);            // below arena start
        send_op(OP_FREE, 0, 20'd8, 0);            // misaligned
        send_op(OP_FREE, 0, 20'hFFFFF, 0);
        a = live_addrs[0]; b = live_addrs[1]; c = live_addrs[2];
        send_op(OP_FREE, 0, a, 0);
        send_op(OP_FREE, 0, a, 0);                // double free
        send_op(OP_FREE, 0, c, 0);
        send_op(OP_FREE, 0, b, 0);                // merge on both sides
        send_op(OP_RESIZE, 40, 0, 1);             // null resize allocates
        a = pick_live();
        send_op(OP_RESIZE, 8, a, 0);              // large enough, kept
        send_op(OP_RESIZE, 500, a, 0);            // grows, moves
        send_op(OP_RESIZE, 0, pick_live(), 0);    // resize to zero frees
        send_op(OP_RESIZE, 64, 20'd0, 0);         // bad address
        send_op(OP_RESET, 0, 0, 0);
        send_op(OP_ALLOC, ARENA_BYTES - 16, 0, 0); // whole arena
        send_op(OP_FREE, 0, 20'd16, 0);
        wait_drained();
    endtask

    task automatic test_random(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 2) begin
                send_op(OP_RESET, $urandom(), 20'($urandom()), 1'($urandom()));
            end else if (k < 45 && live_addrs.size() < 60) begin
                send_op(OP_ALLOC, rand_size(), 20'($urandom()), 1'($urandom()));
            end else if (k < 75) begin
                if ($urandom_range(0, 9) == 0)
                    send_op(OP_FREE, $urandom(), 20'($urandom()), 1'($urandom()));
                else
                    send_op(OP_FREE, $urandom(), pick_live(), 0);
            end else begin
                if ($urandom_range(0, 9) == 0)
                    send_op(OP_RESIZE, rand_size(), 20'($urandom()), 1'($urandom()));
                else
                    send_op(OP_RESIZE, rand_size(), pick_live(), 0);
            end
        end
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) send_op(OP_ALLOC, $urandom_range(1, 200), 0, 0);
        for (int i = 0; i < 12; i++) send_op(OP_FREE, 0, pick_live(), 0);
        wait_drained();
    endtask

    // result side: stall pattern plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req) begin
            m_ready <= 1'b0;
            repeat (STALL_LEN) @(posedge aclk);
            hold_req = 1'b0;
            m_ready <= 1'b1;
        end else if (($urandom_range(0, 255) < 128) && ($urandom_range(0, 3) == 0)) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic cmp_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            fail_count++;
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                cmp_field("result_address", e.result_address, m_data.result_address);
                cmp_field("status", e.status, m_data.status);
                cmp_field("bytes_in_use", e.bytes_in_use, m_data.bytes_in_use);
                cmp_field("peak_in_use", e.peak_in_use, m_data.peak_in_use);
                cmp_field("allocation_count", e.allocation_count,
                          m_data.allocation_count);
                cmp_field("largest_request", e.largest_request, m_data.largest_request);
                cmp_field("failed_request", e.failed_request, m_data.failed_request);
                cmp_field("free_count", e.free_count, m_data.free_count);
                cmp_field("free_matched", e.free_matched, m_data.free_matched);
                cmp_field("free_unmatched", e.free_unmatched, m_data.free_unmatched);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("** first_fit_block_allocator_core: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(380);
        test_backpressure();
        test_random(380);
        if (pending_results.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("** first_fit_block_allocator_core: PASSED **");
        end else begin
            $display("** first_fit_block_allocator_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/ffba_pkg.sv
sv/ffba_ram.sv
sv/ffba_dpath.sv
sv/ffba_ctrl.sv
sv/first_fit_block_allocator_core.sv
sim/tb_first_fit_block_allocator_core.sv
